// ===== rtl/paq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// paq_pkg: shared types and constants of the aging ready queue
// Field widths, action and status codes, controller commands and helpers.
// ----------------------------------------------------------------------------
package paq_pkg;

    // table sizes
    localparam int MAX_TASKS    = 64;
    localparam int QUEUE_DEPTH  = 16;
    localparam int PRIO_FLOOR   = 0;
    localparam int PRIO_CEIL    = 10;

    // field widths
    localparam int ACTION_W   = 3;
    localparam int TASK_W     = 6;
    localparam int BPRIO_W    = 8;
    localparam int EFF_W      = 4;
    localparam int BOOST_W    = 4;
    localparam int STATUS_W   = 2;
    localparam int QUANTUM_W  = 16;
    localparam int QDEPTH_W   = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // derived widths
    localparam int SLOT_W      = $clog2(MAX_TASKS);
    localparam int SLOT_CALC_W = (TASK_W > SLOT_W) ? TASK_W : SLOT_W;
    localparam int Q_IDX_W     = $clog2(QUEUE_DEPTH);
    localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int QENT_W      = TASK_W + EFF_W;

    typedef enum logic [ACTION_W-1:0] {
        ACT_ARRIVE    = 3'd0,
        ACT_COMPLETE  = 3'd1,
        ACT_IO_DONE   = 3'd2,
        ACT_SLICE_END = 3'd3,
        ACT_PICK      = 3'd4
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_AGING_STEP = 2'd0,
        CFG_MAX_BOOST  = 2'd1,
        CFG_QUANTUM    = 2'd2
    } cfg_reg_t;

    // controller to datapath
    typedef struct packed {
        logic latch;
        logic set_empty;
        logic update;
        logic scan_init;
        logic scan_step;
        logic shift_init;
        logic shift_step;
        logic pop;
        logic finish;
    } paq_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_pick;
        logic is_update;
        logic q_empty;
        logic walk_done;
    } paq_stat_t;

    // task id to boost table slot
    function automatic logic [SLOT_W-1:0] slot_of(input logic [TASK_W-1:0] id);
        logic [SLOT_CALC_W-1:0] wide;
        wide = SLOT_CALC_W'(id);
        return SLOT_W'(wide % MAX_TASKS);
    endfunction

    // static priority clamped into the valid range
    function automatic logic [EFF_W-1:0] clamp_prio(input logic signed [BPRIO_W-1:0] p);
        logic [EFF_W-1:0] r;
        if (p < PRIO_FLOOR)
            r = EFF_W'(PRIO_FLOOR);
        else if (p > PRIO_CEIL)
            r = EFF_W'(PRIO_CEIL);
        else
            r = p[EFF_W-1:0];
        return r;
    endfunction

endpackage

// ===== rtl/paq_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// paq_if: request and response channels of the aging ready queue
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface paq_req_if;
    import paq_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [ACTION_W-1:0]        action;
    logic [TASK_W-1:0]          task_id;
    logic signed [BPRIO_W-1:0]  base_priority;

    modport source (output valid, action, task_id, base_priority, input ready);
    modport sink   (input valid, action, task_id, base_priority, output ready);
endinterface

interface paq_rsp_if;
    import paq_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [STATUS_W-1:0]   status;
    logic [TASK_W-1:0]     picked_task;
    logic [EFF_W-1:0]      picked_priority;
    logic [QUANTUM_W-1:0]  slice_ms;
    logic [QDEPTH_W-1:0]   queue_depth;

    modport source (output valid, status, picked_task, picked_priority, slice_ms,
                    queue_depth, input ready);
    modport sink   (input valid, status, picked_task, picked_priority, slice_ms,
                    queue_depth, output ready);
endinterface

// ===== rtl/paq_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// paq_ram: generic single-write, single-read RAM
// One write and one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
module paq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/paq_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// paq_ctrl: sequencer of the aging ready queue
// Steps each beat through boost read, update or scan and compaction,
// and owns the response valid flag.
// ----------------------------------------------------------------------------
module paq_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    input  paq_pkg::paq_stat_t stat,
    output paq_pkg::paq_cmd_t  cmd
);
    import paq_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_BOOST_RD,
        S_UPDATE,
        S_SCAN,
        S_SHIFT,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_BOOST_RD;
                end
            end
            S_BOOST_RD:
            begin
                if (stat.is_pick)
                begin
                    if (stat.q_empty)
                    begin
                        cmd.set_empty = 1'b1;
                        state_next    = S_FINISH;
                    end
                    else
                    begin
                        cmd.scan_init = 1'b1;
                        state_next    = S_SCAN;
                    end
                end
                else if (stat.is_update)
                begin
                    state_next = S_UPDATE;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = S_FINISH;
            end
            S_SCAN:
            begin
                if (stat.walk_done)
                begin
                    cmd.shift_init = 1'b1;
                    state_next     = S_SHIFT;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            S_SHIFT:
            begin
                if (stat.walk_done)
                begin
                    cmd.pop    = 1'b1;
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.shift_step = 1'b1;
                end
            end
            S_FINISH:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // response valid flag
    always_comb
    begin
        if (cmd.finish)
            rsp_valid_next = 1'b1;
        else if (rsp_ready)
            rsp_valid_next = 1'b0;
        else
            rsp_valid_next = rsp_valid_reg;
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;

endmodule

// ===== rtl/paq_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// paq_dp: datapath of the aging ready queue
// Boost table RAM with per-entry valid flags, queue RAM, queue count,
// min-priority scan, compaction, configuration and response registers.
// ----------------------------------------------------------------------------
module paq_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  paq_pkg::paq_cmd_t                 cmd,
    output paq_pkg::paq_stat_t                stat,
    input  logic [paq_pkg::ACTION_W-1:0]      req_action,
    input  logic [paq_pkg::TASK_W-1:0]        req_task_id,
    input  logic signed [paq_pkg::BPRIO_W-1:0] req_base_priority,
    input  logic                              cfg_we,
    input  logic [paq_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [paq_pkg::CFG_DATA_W-1:0]    cfg_data,
    output logic [paq_pkg::STATUS_W-1:0]      rsp_status,
    output logic [paq_pkg::TASK_W-1:0]        rsp_picked_task,
    output logic [paq_pkg::EFF_W-1:0]         rsp_picked_priority,
    output logic [paq_pkg::QUANTUM_W-1:0]     rsp_slice_ms,
    output logic [paq_pkg::QDEPTH_W-1:0]      rsp_queue_depth
);
    import paq_pkg::*;

    // configuration
    logic [BOOST_W-1:0]   aging_step_reg;
    logic [BOOST_W-1:0]   max_boost_reg;
    logic [QUANTUM_W-1:0] quantum_reg;

    // current beat
    action_t                   act_reg;
    logic [TASK_W-1:0]         task_reg;
    logic signed [BPRIO_W-1:0] bprio_reg;

    // queue and walk state
    logic [Q_CNT_W-1:0]   count_reg;
    logic [Q_CNT_W-1:0]   count_next;
    logic [MAX_TASKS-1:0] bvalid_reg;
    logic [Q_CNT_W-1:0]   rd_reg;
    logic [Q_CNT_W-1:0]   rd_next;
    logic                 pend_reg;
    logic                 pend_next;
    logic [Q_IDX_W-1:0]   pend_idx_reg;
    logic [Q_IDX_W-1:0]   best_idx_reg;
    logic [EFF_W-1:0]     best_prio_reg;
    logic [TASK_W-1:0]    best_task_reg;

    // staged result
    status_t              st_status_reg;
    logic [TASK_W-1:0]    st_task_reg;
    logic [EFF_W-1:0]     st_prio_reg;
    logic                 picked_reg;

    // response payload
    logic [STATUS_W-1:0]  out_status_reg;
    logic [TASK_W-1:0]    out_task_reg;
    logic [EFF_W-1:0]     out_prio_reg;
    logic [QUANTUM_W-1:0] out_slice_reg;
    logic [QDEPTH_W-1:0]  out_depth_reg;

    // combinational helpers
    logic [SLOT_W-1:0]    slot;
    logic [BOOST_W-1:0]   boost_rdata;
    logic [BOOST_W-1:0]   old_boost;
    logic [BOOST_W-1:0]   step;
    logic [BOOST_W:0]     boost_sum;
    logic [BOOST_W-1:0]   new_boost;
    logic [EFF_W-1:0]     base_clamped;
    logic [EFF_W-1:0]     eff;
    logic                 is_enq;
    logic                 is_upd;
    logic                 q_full;
    logic                 issue;
    logic [QENT_W-1:0]    q_rdata;
    logic [TASK_W-1:0]    q_task;
    logic [EFF_W-1:0]     q_prio;
    logic                 q_we;
    logic [Q_IDX_W-1:0]   q_waddr;
    logic [QENT_W-1:0]    q_wdata;
    logic                 take_best;

    // action decode
    always_comb
    begin
        is_enq = 1'b0;
        is_upd = 1'b0;
        unique case (act_reg) inside
            ACT_ARRIVE, ACT_IO_DONE, ACT_SLICE_END:
            begin
                is_enq = 1'b1;
                is_upd = 1'b1;
            end
            ACT_COMPLETE:
            begin
                is_upd = 1'b1;
            end
            default:
            begin
                is_enq = 1'b0;
            end
        endcase
    end

    assign slot = slot_of(task_reg);

    // boost table, unwritten entries read as zero
    paq_ram #(
        .WIDTH (BOOST_W),
        .DEPTH (MAX_TASKS)
    ) u_boost_ram (
        .clk   (clk),
        .we    (cmd.update),
        .waddr (slot),
        .wdata (new_boost),
        .raddr (slot),
        .rdata (boost_rdata)
    );

    assign old_boost = bvalid_reg[slot] ? boost_rdata : '0;
    assign step      = (aging_step_reg == '0) ? BOOST_W'(1) : aging_step_reg;
    assign boost_sum = {1'b0, old_boost} + {1'b0, step};

    // new boost: aged and saturated on I/O done and slice end, cleared otherwise
    always_comb
    begin
        if (act_reg == ACT_IO_DONE || act_reg == ACT_SLICE_END)
        begin
            if (boost_sum > {1'b0, max_boost_reg})
                new_boost = max_boost_reg;
            else
                new_boost = boost_sum[BOOST_W-1:0];
        end
        else
        begin
            new_boost = '0;
        end
    end

    // frozen effective priority
    assign base_clamped = clamp_prio(bprio_reg);
    assign eff = (base_clamped > EFF_W'(new_boost)) ? base_clamped - EFF_W'(new_boost) : '0;
    assign q_full = (count_reg == Q_CNT_W'(QUEUE_DEPTH));

    // queue RAM: append on enqueue, move down by one on compaction
    assign q_we    = (cmd.update && is_enq && !q_full) || (cmd.shift_step && pend_reg);
    assign q_waddr = cmd.update ? count_reg[Q_IDX_W-1:0] : pend_idx_reg - Q_IDX_W'(1);
    assign q_wdata = cmd.update ? {task_reg, eff} : q_rdata;

    paq_ram #(
        .WIDTH (QENT_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue_ram (
        .clk   (clk),
        .we    (q_we),
        .waddr (q_waddr),
        .wdata (q_wdata),
        .raddr (rd_reg[Q_IDX_W-1:0]),
        .rdata (q_rdata)
    );

    assign q_task = q_rdata[QENT_W-1:EFF_W];
    assign q_prio = q_rdata[EFF_W-1:0];

    // walk over the queue: one read issued per step, data compared in the cycle after
    assign issue     = (rd_reg < count_reg);
    assign take_best = cmd.scan_step && pend_reg &&
                       ((pend_idx_reg == '0) || (q_prio < best_prio_reg));

    always_comb
    begin
        rd_next   = rd_reg;
        pend_next = pend_reg;
        if (cmd.scan_init)
        begin
            rd_next   = '0;
            pend_next = 1'b0;
        end
        else if (cmd.shift_init)
        begin
            rd_next   = Q_CNT_W'(best_idx_reg) + Q_CNT_W'(1);
            pend_next = 1'b0;
        end
        else if (cmd.scan_step || cmd.shift_step)
        begin
            rd_next   = issue ? rd_reg + Q_CNT_W'(1) : rd_reg;
            pend_next = issue;
        end
    end

    // queue count
    always_comb
    begin
        count_next = count_reg;
        if (cmd.update && is_enq && !q_full)
            count_next = count_reg + Q_CNT_W'(1);
        else if (cmd.pop)
            count_next = count_reg - Q_CNT_W'(1);
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            aging_step_reg <= BOOST_W'(1);
            max_boost_reg  <= BOOST_W'(5);
            quantum_reg    <= QUANTUM_W'(10);
            count_reg      <= '0;
            bvalid_reg     <= '0;
            rd_reg         <= '0;
            pend_reg       <= 1'b0;
            st_status_reg  <= ST_OK;
            picked_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_AGING_STEP: aging_step_reg <= cfg_data[BOOST_W-1:0];
                    CFG_MAX_BOOST:  max_boost_reg  <= cfg_data[BOOST_W-1:0];
                    CFG_QUANTUM:    quantum_reg    <= cfg_data[QUANTUM_W-1:0];
                    default:        quantum_reg    <= quantum_reg;
                endcase
            end
            count_reg <= count_next;
            rd_reg    <= rd_next;
            pend_reg  <= pend_next;
            if (cmd.update)
            begin
                bvalid_reg[slot] <= 1'b1;
            end
            if (cmd.latch)
            begin
                st_status_reg <= ST_OK;
                picked_reg    <= 1'b0;
            end
            else if (cmd.set_empty)
            begin
                st_status_reg <= ST_EMPTY;
            end
            else if (cmd.update && is_enq && q_full)
            begin
                st_status_reg <= ST_FULL;
            end
            else if (cmd.pop)
            begin
                picked_reg <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            act_reg     <= action_t'(req_action);
            task_reg    <= req_task_id;
            bprio_reg   <= req_base_priority;
            st_task_reg <= '0;
            st_prio_reg <= '0;
        end
        if (cmd.scan_step || cmd.shift_step)
        begin
            pend_idx_reg <= rd_reg[Q_IDX_W-1:0];
        end
        if (take_best)
        begin
            best_idx_reg  <= pend_idx_reg;
            best_prio_reg <= q_prio;
            best_task_reg <= q_task;
        end
        if (cmd.shift_init)
        begin
            st_task_reg <= best_task_reg;
            st_prio_reg <= best_prio_reg;
        end
        if (cmd.finish)
        begin
            out_status_reg <= st_status_reg;
            out_task_reg   <= picked_reg ? st_task_reg : '0;
            out_prio_reg   <= picked_reg ? st_prio_reg : '0;
            if (!picked_reg)
                out_slice_reg <= '0;
            else if (quantum_reg == '0)
                out_slice_reg <= QUANTUM_W'(1);
            else
                out_slice_reg <= quantum_reg;
            out_depth_reg <= QDEPTH_W'(count_reg);
        end
    end

    // status to the controller
    assign stat.is_pick   = (act_reg == ACT_PICK);
    assign stat.is_update = is_upd;
    assign stat.q_empty   = (count_reg == '0);
    assign stat.walk_done = !issue && !pend_reg;

    assign rsp_status          = out_status_reg;
    assign rsp_picked_task     = out_task_reg;
    assign rsp_picked_priority = out_prio_reg;
    assign rsp_slice_ms        = out_slice_reg;
    assign rsp_queue_depth     = out_depth_reg;

endmodule

// ===== rtl/priority_aging_ready_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_aging_ready_queue: ready-queue scheduler with per-task aging boosts
// An enqueue or completion steps through boost read, update and finish; an empty
// pick or an unused action goes from boost read straight to finish.
// A pick scans every queued entry for the lowest priority, then compacts the entries
// behind the one taken, through the single queue RAM read port (scan, then
// compaction, one entry/cycle).
// One request in flight; the next is taken as soon as the response is loaded,
// even while that response still waits.
// Reset: empty queue, configuration registers to defaults, boosts read as zero at once.
// ----------------------------------------------------------------------------
module priority_aging_ready_queue (
    input  logic                               clk,
    input  logic                               rst_n,
    paq_req_if.sink                            req,
    paq_rsp_if.source                          rsp,
    input  logic                               cfg_we,
    input  logic [paq_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [paq_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import paq_pkg::*;

    paq_cmd_t  cmd;
    paq_stat_t stat;

    // sequencer
    paq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // datapath
    paq_dp u_dp (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cmd                 (cmd),
        .stat                (stat),
        .req_action          (req.action),
        .req_task_id         (req.task_id),
        .req_base_priority   (req.base_priority),
        .cfg_we              (cfg_we),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .rsp_status          (rsp.status),
        .rsp_picked_task     (rsp.picked_task),
        .rsp_picked_priority (rsp.picked_priority),
        .rsp_slice_ms        (rsp.slice_ms),
        .rsp_queue_depth     (rsp.queue_depth)
    );

endmodule

// ===== verif/tb_priority_aging_ready_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_priority_aging_ready_queue: self-checking bench of the aging ready queue
// A scheduler model tracks boosts, the ready list and the register values. It
// predicts one response per accepted request beat. Every response beat is
// compared field by field in arrival order. Directed tests cover clamping,
// FIFO ties, aging, the special register values and unused actions. A
// back-pressure test then fills the queue while the response side stalls. Last
// come random phases under several register settings, with random gaps on
// both channels in most phases.
// ----------------------------------------------------------------------------
module tb_priority_aging_ready_queue;
    import paq_pkg::*;

    localparam logic [ACTION_W-1:0]  ACT_UNUSED_LO  = 3'd5;
    localparam logic [ACTION_W-1:0]  ACT_UNUSED_HI  = 3'd7;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;
    localparam int DRAIN_CYCLES     = 48;
    localparam int PHASE_ITEMS      = 200;
    localparam int RANDOM_PHASES    = 8;
    localparam int PRESSURE_HOLD    = 300;

    typedef struct {
        logic [STATUS_W-1:0]  status;
        logic [TASK_W-1:0]    picked_task;
        logic [EFF_W-1:0]     picked_priority;
        logic [QUANTUM_W-1:0] slice_ms;
        logic [QDEPTH_W-1:0]  queue_depth;
    } sched_result_t;

    typedef struct {
        logic [TASK_W-1:0] tid;
        logic [EFF_W-1:0]  eff;
    } ready_entry_t;

    logic clk;
    logic rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    paq_req_if req_ch ();
    paq_rsp_if rsp_ch ();

    // scheduler model state
    logic [BOOST_W-1:0]   boost_tbl [MAX_TASKS];
    ready_entry_t         ready_list [$];
    logic [BOOST_W-1:0]   cur_step;
    logic [BOOST_W-1:0]   cur_max_boost;
    logic [QUANTUM_W-1:0] cur_quantum;

    sched_result_t expected_rsp_q [$];
    int            err_count;
    bit            gaps_on;
    int            rsp_hold_len;

    priority_aging_ready_queue dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // mismatch report
    task automatic report_mismatch(input string what, input int got, input int want);
        $display("ERROR at %0t: %s got %0d expected %0d", $time, what, got, want);
        err_count++;
    endtask

    // gap length: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    // freeze the effective priority and append to the ready list
    function automatic logic [STATUS_W-1:0] enqueue_task(input logic [TASK_W-1:0] id,
                                                         input logic signed [BPRIO_W-1:0] prio);
        int base;
        int eff;
        int slot;
        ready_entry_t ent;
        slot = id % MAX_TASKS;
        if (prio < PRIO_FLOOR)
            base = PRIO_FLOOR;
        else if (prio > PRIO_CEIL)
            base = PRIO_CEIL;
        else
            base = prio;
        if (boost_tbl[slot] > cur_max_boost)
            boost_tbl[slot] = cur_max_boost;
        eff = base - int'(boost_tbl[slot]);
        if (eff < PRIO_FLOOR)
            eff = PRIO_FLOOR;
        if (ready_list.size() >= QUEUE_DEPTH)
            return ST_FULL;
        ent.tid = id;
        ent.eff = eff[EFF_W-1:0];
        ready_list.push_back(ent);
        return ST_OK;
    endfunction

    // expected response for one request beat, state updated on the way
    function automatic sched_result_t predict_action(input logic [ACTION_W-1:0] act,
                                                     input logic [TASK_W-1:0] id,
                                                     input logic signed [BPRIO_W-1:0] prio);
        sched_result_t res;
        int slot;
        int boosted;
        int best;
        res = '{ST_OK, '0, '0, '0, '0};
        slot = id % MAX_TASKS;
        case (act)
            ACT_ARRIVE:
            begin
                boost_tbl[slot] = '0;
                res.status = enqueue_task(id, prio);
            end
            ACT_COMPLETE:
            begin
                boost_tbl[slot] = '0;
            end
            ACT_IO_DONE, ACT_SLICE_END:
            begin
                boosted = int'(boost_tbl[slot]) + ((cur_step == 0) ? 1 : int'(cur_step));
                if (boosted > cur_max_boost)
                    boosted = cur_max_boost;
                boost_tbl[slot] = boosted[BOOST_W-1:0];
                res.status = enqueue_task(id, prio);
            end
            ACT_PICK:
            begin
                if (ready_list.size() == 0)
                begin
                    res.status = ST_EMPTY;
                end
                else
                begin
                    best = 0;
                    for (int i = 1; i < ready_list.size(); i++)
                        if (ready_list[i].eff < ready_list[best].eff)
                            best = i;
                    res.picked_task     = ready_list[best].tid;
                    res.picked_priority = ready_list[best].eff;
                    res.slice_ms        = (cur_quantum == 0) ? QUANTUM_W'(1) : cur_quantum;
                    ready_list.delete(best);
                end
            end
            default:
            begin
            end
        endcase
        res.queue_depth = QDEPTH_W'(ready_list.size());
        return res;
    endfunction

    // register write seen by the model
    function automatic void apply_config(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_AGING_STEP: cur_step      = data[BOOST_W-1:0];
            CFG_MAX_BOOST:  cur_max_boost = data[BOOST_W-1:0];
            CFG_QUANTUM:    cur_quantum   = data[QUANTUM_W-1:0];
            default:
            begin
            end
        endcase
    endfunction

    // predict on request beats, check on response beats
    always @(posedge clk)
    begin : beat_monitor
        sched_result_t want;
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (expected_rsp_q.size() == 0)
                begin
                    report_mismatch("response beat with nothing pending", 1, 0);
                end
                else
                begin
                    want = expected_rsp_q.pop_front();
                    if (rsp_ch.status !== want.status)
                        report_mismatch("status", rsp_ch.status, want.status);
                    if (rsp_ch.picked_task !== want.picked_task)
                        report_mismatch("picked_task", rsp_ch.picked_task, want.picked_task);
                    if (rsp_ch.picked_priority !== want.picked_priority)
                        report_mismatch("picked_priority", rsp_ch.picked_priority,
                                        want.picked_priority);
                    if (rsp_ch.slice_ms !== want.slice_ms)
                        report_mismatch("slice_ms", rsp_ch.slice_ms, want.slice_ms);
                    if (rsp_ch.queue_depth !== want.queue_depth)
                        report_mismatch("queue_depth", rsp_ch.queue_depth, want.queue_depth);
                end
            end
            if (cfg_we)
                apply_config(cfg_index, cfg_data);
            if (req_ch.valid && req_ch.ready)
                expected_rsp_q.push_back(predict_action(req_ch.action, req_ch.task_id,
                                                        req_ch.base_priority));
        end
    end

    // response ready: random stalls, plus long hold-offs on request
    initial
    begin : rsp_ready_driver
        int n;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_hold_len > 0)
            begin
                n = rsp_hold_len;
                rsp_hold_len = 0;
                rsp_ch.ready <= 1'b0;
                repeat (n) @(posedge clk);
                rsp_ch.ready <= 1'b1;
            end
            else if (gaps_on && $urandom_range(0, 3) == 0)
            begin
                n = pick_gap();
                rsp_ch.ready <= 1'b0;
                repeat (n + 1) @(posedge clk);
                rsp_ch.ready <= 1'b1;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // send one request beat; valid stays high for a following beat
    task automatic send_req(input logic [ACTION_W-1:0] act, input logic [TASK_W-1:0] id,
                            input logic [BPRIO_W-1:0] prio);
        int gap;
        gap = gaps_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.action        <= act;
        req_ch.task_id       <= id;
        req_ch.base_priority <= prio;
        do
            @(posedge clk);
        while (!req_ch.ready);
    endtask

    // drop valid and wait until every response is back and the block is quiet
    task automatic wait_for_idle();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_rsp_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // write all registers, junk in the unused upper bits
    task automatic program_regs(input logic [BOOST_W-1:0] step, input logic [BOOST_W-1:0] maxb,
                                input logic [QUANTUM_W-1:0] quantum, input bit with_unused);
        logic [CFG_DATA_W-1:0] val [4];
        val[CFG_AGING_STEP] = {12'($urandom_range(0, 4095)), step};
        val[CFG_MAX_BOOST]  = {12'($urandom_range(0, 4095)), maxb};
        val[CFG_QUANTUM]    = quantum;
        val[CFG_UNUSED_IDX] = 16'($urandom_range(0, 65535));
        for (int i = 0; i <= (with_unused ? int'(CFG_UNUSED_IDX) : int'(CFG_QUANTUM)); i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= i[CFG_IDX_W-1:0];
            cfg_data  <= val[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    // empty pick and the unused action codes
    task automatic test_empty_and_unused();
        send_req(ACT_PICK, 6'($urandom_range(0, 63)), 8'($urandom_range(0, 255)));
        for (int a = ACT_UNUSED_LO; a <= ACT_UNUSED_HI; a++)
            send_req(a[ACTION_W-1:0], 6'($urandom_range(0, 63)), 8'($urandom_range(0, 255)));
        wait_for_idle();
    endtask

    // priority clamping at the field extremes and first-in first-out ties
    task automatic test_clamp_and_ties();
        send_req(ACT_ARRIVE, 6'd0,  8'h80);
        send_req(ACT_ARRIVE, 6'd63, 8'h7F);
        send_req(ACT_ARRIVE, 6'd5,  8'd10);
        send_req(ACT_ARRIVE, 6'd7,  8'd0);
        send_req(ACT_ARRIVE, 6'd9,  8'd11);
        send_req(ACT_ARRIVE, 6'd33, 8'hFF);
        repeat (6) send_req(ACT_PICK, 6'($urandom_range(0, 63)), 8'($urandom_range(0, 255)));
        wait_for_idle();
    endtask

    // aging, completion clearing, zero step and zero quantum, lowered max boost
    task automatic test_aging();
        program_regs(4'd0, 4'd15, 16'd0, 1'b0);
        send_req(ACT_IO_DONE,   6'd12, 8'd10);
        send_req(ACT_SLICE_END, 6'd12, 8'd10);
        send_req(ACT_COMPLETE,  6'd12, 8'd10);
        send_req(ACT_IO_DONE,   6'd12, 8'd10);
        repeat (3) send_req(ACT_PICK, 6'd0, 8'd0);
        wait_for_idle();
        program_regs(4'd15, 4'd15, 16'hFFFF, 1'b0);
        send_req(ACT_SLICE_END, 6'd40, 8'd3);
        send_req(ACT_PICK, 6'd0, 8'd0);
        wait_for_idle();
        // boost now above the new limit
        program_regs(4'd15, 4'd2, 16'hFFFF, 1'b0);
        send_req(ACT_IO_DONE, 6'd40, 8'd10);
        send_req(ACT_PICK, 6'd0, 8'd0);
        wait_for_idle();
    endtask

    // response side held off while requests keep coming: fills and overflows
    task automatic test_backpressure();
        logic [ACTION_W-1:0] act;
        gaps_on = 1'b0;
        program_regs(4'd3, 4'd9, 16'd250, 1'b0);
        rsp_hold_len = PRESSURE_HOLD;
        for (int n = 0; n < QUEUE_DEPTH + 4; n++)
        begin
            case ($urandom_range(0, 2))
                0:       act = ACT_ARRIVE;
                1:       act = ACT_IO_DONE;
                default: act = ACT_SLICE_END;
            endcase
            send_req(act, 6'($urandom_range(0, 7)), 8'($urandom_range(0, 12)));
        end
        repeat (QUEUE_DEPTH + 2) send_req(ACT_PICK, 6'($urandom_range(0, 63)), 8'd0);
        wait_for_idle();
    endtask

    // random phases under varied register settings and traffic mixes
    task automatic test_random_traffic();
        int r;
        int enq_pct;
        logic [ACTION_W-1:0] act;
        logic [TASK_W-1:0]   id;
        logic [BPRIO_W-1:0]  prio;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0:       program_regs(4'd1, 4'd5, 16'd10, 1'b1);
                1:       program_regs(4'd15, 4'd15, 16'hFFFF, 1'b0);
                2:       program_regs(4'd0, 4'd0, 16'd0, 1'b0);
                3:       program_regs(4'd1, 4'd15, 16'd1, 1'b0);
                default: program_regs(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                                      16'($urandom_range(0, 65535)), 1'b0);
            endcase
            gaps_on = (phase % 3) != 2;
            enq_pct = (phase % 2 == 1) ? 72 : 38;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                r = $urandom_range(0, 99);
                if (r < 3)
                    act = 3'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI));
                else if (r < enq_pct)
                    act = 3'($urandom_range(ACT_ARRIVE, ACT_SLICE_END));
                else if (r < enq_pct + 10)
                    act = ACT_COMPLETE;
                else
                    act = ACT_PICK;
                if (act == ACT_COMPLETE)
                    act = ($urandom_range(0, 1) == 0) ? ACT_COMPLETE : ACT_ARRIVE;
                id = ($urandom_range(0, 1) == 0) ? 6'($urandom_range(0, 7))
                                                 : 6'($urandom_range(0, 63));
                if ($urandom_range(0, 9) < 7)
                    prio = 8'($signed($urandom_range(0, 14)) - 2);
                else
                    prio = 8'($urandom_range(0, 255));
                send_req(act, id, prio);
            end
            wait_for_idle();
        end
    endtask

    // run limit
    initial
    begin
        #10_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // main sequence
    initial
    begin
        err_count    = 0;
        gaps_on      = 1'b1;
        rsp_hold_len = 0;
        cur_step      = 4'd1;
        cur_max_boost = 4'd5;
        cur_quantum   = 16'd10;
        for (int i = 0; i < MAX_TASKS; i++)
            boost_tbl[i] = '0;
        rst_n                <= 1'b0;
        cfg_we               <= 1'b0;
        cfg_index            <= '0;
        cfg_data             <= '0;
        req_ch.valid         <= 1'b0;
        req_ch.action        <= '0;
        req_ch.task_id       <= '0;
        req_ch.base_priority <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_empty_and_unused();
        test_clamp_and_ties();
        test_aging();
        test_backpressure();
        test_random_traffic();
        wait_for_idle();

        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
